// ----- src/fragment_depth_test_color_write_defines.svh -----
// Assertion macros shared by the depth test and color write block.
`ifndef FRAGMENT_DEPTH_TEST_COLOR_WRITE_DEFINES_SVH
`define FRAGMENT_DEPTH_TEST_COLOR_WRITE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FDTCW_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdtcw assertion failed");

// Next-cycle implication, checked outside reset.
`define FDTCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdtcw assertion failed");

`endif

// ----- src/fdtcw_pkg.sv -----
// Types, constants and the depth compare function of the depth test block.
package fdtcw_pkg;

  localparam int PIXEL_COUNT = 65536;
  localparam int DEPTH_BITS  = 24;
  localparam int ADDR_BITS   = $clog2(PIXEL_COUNT);
  // y * width + x with 12-bit position and 13-bit width
  localparam int IDX_BITS    = 26;
  localparam int PADDR_BITS  = 4;
  localparam int PDATA_BITS  = 32;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_DEPTH_TEST_ENABLE = 2'd0;
  localparam logic [1:0] REG_DEPTH_FUNC        = 2'd1;
  localparam logic [1:0] REG_VIEWPORT_WIDTH    = 2'd2;

  // compare functions
  localparam logic [2:0] FUNC_NEVER    = 3'd0;
  localparam logic [2:0] FUNC_LESS     = 3'd1;
  localparam logic [2:0] FUNC_EQUAL    = 3'd2;
  localparam logic [2:0] FUNC_LEQUAL   = 3'd3;
  localparam logic [2:0] FUNC_GREATER  = 3'd4;
  localparam logic [2:0] FUNC_NOTEQUAL = 3'd5;
  localparam logic [2:0] FUNC_GEQUAL   = 3'd6;
  localparam logic [2:0] FUNC_ALWAYS   = 3'd7;

  // result outcomes
  localparam logic [2:0] OUT_WRITTEN    = 3'd0;
  localparam logic [2:0] OUT_GHOST      = 3'd1;
  localparam logic [2:0] OUT_KILLED     = 3'd2;
  localparam logic [2:0] OUT_DEPTH_FAIL = 3'd3;
  localparam logic [2:0] OUT_RANGE      = 3'd4;

  typedef struct packed {
    logic        depth_test_enable;
    logic [2:0]  depth_func;
    logic [12:0] viewport_width;
  } cfg_t;

  function automatic logic depth_pass(input logic [2:0] func,
                                      input logic [DEPTH_BITS-1:0] frag,
                                      input logic [DEPTH_BITS-1:0] stored);
    logic pass;
    unique case (func)
      FUNC_NEVER:    pass = 1'b0;
      FUNC_LESS:     pass = frag <  stored;
      FUNC_EQUAL:    pass = frag == stored;
      FUNC_LEQUAL:   pass = frag <= stored;
      FUNC_GREATER:  pass = frag >  stored;
      FUNC_NOTEQUAL: pass = frag != stored;
      FUNC_GEQUAL:   pass = frag >= stored;
      FUNC_ALWAYS:   pass = 1'b1;
      default:       pass = 1'b0;
    endcase
    return pass;
  endfunction

endpackage

// ----- src/fragment_depth_test_color_write.sv -----
// Top level: fragment depth test and color write around the depth store RAM.
//
// Fragments enter on the in channel (in_valid / in_stall) and leave as one
// result each on the out channel (out_valid / out_stall). Every fragment
// gives exactly one result: a color write, or a drop with its reason.
// The pixel index y * viewport_width + x is formed as the fragment is taken.
// The depth store is read in the next cycle, and in the cycle after that the
// compare runs; a passing depth is written back and the result register is
// loaded together, once the result register is free. The read-compare-write
// of the single depth store RAM runs one fragment at a time: a new fragment
// is taken only after the last one's result has been loaded.
// After reset the depth store is swept to the far depth, one entry a cycle:
// in_stall stays high until every entry is written. Settings take their
// reset values and may be written over APB at any time the block is idle.
// When the receiver stalls, the result register holds its result and the
// next fragment waits at the compare step until the register frees up.
module fragment_depth_test_color_write (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fdtcw_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [fdtcw_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [fdtcw_pkg::PDATA_BITS-1:0]  prdata,
  output logic                              pready,
  // fragment input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [11:0]                       pos_x,
  input  logic [11:0]                       pos_y,
  input  logic [23:0]                       frag_depth,
  input  logic [7:0]                        red_in,
  input  logic [7:0]                        green_in,
  input  logic [7:0]                        blue_in,
  input  logic [7:0]                        alpha_in,
  input  logic                              is_ghost,
  input  logic                              is_killed,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        outcome,
  output logic                              color_write,
  output logic [15:0]                       pixel_index,
  output logic [7:0]                        red_out,
  output logic [7:0]                        green_out,
  output logic [7:0]                        blue_out,
  output logic [7:0]                        alpha_out
);

`include "fragment_depth_test_color_write_defines.svh"

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_TEST  = 4'b1000
  } state_t;

  state_t state, state_next;

  fdtcw_pkg::cfg_t cfg;

  logic [fdtcw_pkg::ADDR_BITS-1:0]  clr_addr;
  logic [fdtcw_pkg::IDX_BITS-1:0]   idx_calc;
  logic [fdtcw_pkg::IDX_BITS-1:0]   idx;
  logic [fdtcw_pkg::DEPTH_BITS-1:0] depth;
  logic [7:0]                       red, green, blue, alpha;
  logic                             ghost, killed;

  logic                             in_take;
  logic                             commit;
  logic                             out_free;
  logic                             out_range;
  logic                             pass;
  logic [2:0]                       outcome_next;
  logic                             write_next;
  logic                             depth_we;

  logic                             ram_we;
  logic [fdtcw_pkg::ADDR_BITS-1:0]  ram_waddr;
  logic [fdtcw_pkg::DEPTH_BITS-1:0] ram_wdata;
  logic [fdtcw_pkg::DEPTH_BITS-1:0] ram_rdata;

  fdtcw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fdtcw_ram #(
    .WIDTH (fdtcw_pkg::DEPTH_BITS),
    .DEPTH (fdtcw_pkg::PIXEL_COUNT)
  ) u_depth_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx[fdtcw_pkg::ADDR_BITS-1:0]),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == S_TEST) && out_free;

  assign idx_calc = fdtcw_pkg::IDX_BITS'(pos_y) * fdtcw_pkg::IDX_BITS'(cfg.viewport_width)
                  + fdtcw_pkg::IDX_BITS'(pos_x);

  // capture the fragment and its pixel index
  always_ff @(posedge clk) begin
    if (in_take) begin
      idx    <= idx_calc;
      depth  <= frag_depth;
      red    <= red_in;
      green  <= green_in;
      blue   <= blue_in;
      alpha  <= alpha_in;
      ghost  <= is_ghost;
      killed <= is_killed;
    end
  end

  assign out_range = (idx[fdtcw_pkg::IDX_BITS-1:fdtcw_pkg::ADDR_BITS] != '0);
  assign pass      = fdtcw_pkg::depth_pass(cfg.depth_func, depth, ram_rdata);

  always_comb begin
    outcome_next = fdtcw_pkg::OUT_WRITTEN;
    write_next   = 1'b0;
    depth_we     = 1'b0;
    priority if (ghost) begin
      outcome_next = fdtcw_pkg::OUT_GHOST;
    end else if (killed) begin
      outcome_next = fdtcw_pkg::OUT_KILLED;
    end else if (out_range) begin
      outcome_next = fdtcw_pkg::OUT_RANGE;
    end else if (cfg.depth_test_enable && !pass) begin
      outcome_next = fdtcw_pkg::OUT_DEPTH_FAIL;
    end else begin
      outcome_next = fdtcw_pkg::OUT_WRITTEN;
      write_next   = 1'b1;
      depth_we     = cfg.depth_test_enable;
    end
  end

  // write port: clearing sweep, then depth write-back at commit
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '1;
    end else begin
      ram_we    = commit && depth_we;
      ram_waddr = idx[fdtcw_pkg::ADDR_BITS-1:0];
      ram_wdata = depth;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == '1) state_next = S_IDLE;
      S_IDLE:  if (in_take) state_next = S_READ;
      S_READ:  state_next = S_TEST;
      S_TEST:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      outcome     <= outcome_next;
      color_write <= write_next;
      pixel_index <= (ghost || killed) ? 16'd0 : idx[15:0];
      red_out     <= write_next ? red   : 8'd0;
      green_out   <= write_next ? green : 8'd0;
      blue_out    <= write_next ? blue  : 8'd0;
      alpha_out   <= write_next ? alpha : 8'd0;
    end
  end

  `FDTCW_ASSERT_IMPL(a_write_outcome, clk, rst, out_valid && color_write,
    outcome == fdtcw_pkg::OUT_WRITTEN)
  `FDTCW_ASSERT_IMPL(a_drop_no_color, clk, rst, out_valid && !color_write,
    red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0 && alpha_out == 8'd0)
  `FDTCW_ASSERT_IMPL(a_depth_write_only_at_commit, clk, rst,
    ram_we && state != S_CLEAR, commit && cfg.depth_test_enable && !out_range)
  `FDTCW_ASSERT_NEXT(a_read_then_test, clk, rst, state == S_READ, state == S_TEST)

endmodule

// ----- src/fdtcw_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module fdtcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/fdtcw_cfg.sv -----
// APB register file holding the depth test and viewport settings.
module fdtcw_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fdtcw_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [fdtcw_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [fdtcw_pkg::PDATA_BITS-1:0]  prdata,
  output logic                              pready,
  output fdtcw_pkg::cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_test_enable <= 1'b0;
      cfg.depth_func        <= fdtcw_pkg::FUNC_LESS;
      cfg.viewport_width    <= 13'd256;
    end else if (wr_en) begin
      unique case (reg_sel)
        fdtcw_pkg::REG_DEPTH_TEST_ENABLE: cfg.depth_test_enable <= pwdata[0];
        fdtcw_pkg::REG_DEPTH_FUNC:        cfg.depth_func        <= pwdata[2:0];
        fdtcw_pkg::REG_VIEWPORT_WIDTH:    cfg.viewport_width    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      fdtcw_pkg::REG_DEPTH_TEST_ENABLE:
        prdata = fdtcw_pkg::PDATA_BITS'(cfg.depth_test_enable);
      fdtcw_pkg::REG_DEPTH_FUNC:
        prdata = fdtcw_pkg::PDATA_BITS'(cfg.depth_func);
      fdtcw_pkg::REG_VIEWPORT_WIDTH:
        prdata = fdtcw_pkg::PDATA_BITS'(cfg.viewport_width);
      default:
        prdata = '0;
    endcase
  end

endmodule

// ----- verif/fragment_depth_test_color_write_checker.sv -----
// Checker for the depth test block: predicts each fragment's fate and compares results.
module fragment_depth_test_color_write_checker
  import fdtcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  input  logic                  pready,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [11:0]           pos_x,
  input  logic [11:0]           pos_y,
  input  logic [23:0]           frag_depth,
  input  logic [7:0]            red_in,
  input  logic [7:0]            green_in,
  input  logic [7:0]            blue_in,
  input  logic [7:0]            alpha_in,
  input  logic                  is_ghost,
  input  logic                  is_killed,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [2:0]            outcome,
  input  logic                  color_write,
  input  logic [15:0]           pixel_index,
  input  logic [7:0]            red_out,
  input  logic [7:0]            green_out,
  input  logic [7:0]            blue_out,
  input  logic [7:0]            alpha_out,
  output int                    fail_count,
  output int                    pending,
  output int                    written_count,
  output int                    drop_count,
  output int                    depth_fail_count,
  output int                    range_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  outcome;
    logic        color_write;
    logic [15:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } fate_t;

  logic [DEPTH_BITS-1:0] depth_mem [PIXEL_COUNT];
  cfg_t                  raster_cfg;
  fate_t                 predicted_fates [$];
  int                    result_no;

  function automatic logic depth_test_passes(input logic [2:0] func,
                                             input logic [DEPTH_BITS-1:0] frag,
                                             input logic [DEPTH_BITS-1:0] stored);
    case (func)
      FUNC_NEVER:    return 1'b0;
      FUNC_LESS:     return frag < stored;
      FUNC_EQUAL:    return frag == stored;
      FUNC_LEQUAL:   return frag <= stored;
      FUNC_GREATER:  return frag > stored;
      FUNC_NOTEQUAL: return frag != stored;
      FUNC_GEQUAL:   return frag >= stored;
      default:       return 1'b1;
    endcase
  endfunction

  // Decide the fate of the fragment on the input ports; update the depth copy.
  function automatic fate_t resolve_fragment();
    fate_t              fate;
    logic [IDX_BITS-1:0] idx;
    fate = '0;
    if (is_ghost) begin
      fate.outcome = OUT_GHOST;
    end else if (is_killed) begin
      fate.outcome = OUT_KILLED;
    end else begin
      idx = IDX_BITS'(pos_y) * IDX_BITS'(raster_cfg.viewport_width) + IDX_BITS'(pos_x);
      fate.pixel_index = idx[15:0];
      if (idx >= PIXEL_COUNT) begin
        fate.outcome = OUT_RANGE;
      end else if (raster_cfg.depth_test_enable &&
                   !depth_test_passes(raster_cfg.depth_func, frag_depth,
                                      depth_mem[idx[ADDR_BITS-1:0]])) begin
        fate.outcome = OUT_DEPTH_FAIL;
      end else begin
        if (raster_cfg.depth_test_enable) depth_mem[idx[ADDR_BITS-1:0]] = frag_depth;
        fate.outcome     = OUT_WRITTEN;
        fate.color_write = 1'b1;
        fate.red         = red_in;
        fate.green       = green_in;
        fate.blue        = blue_in;
        fate.alpha       = alpha_in;
      end
    end
    return fate;
  endfunction

  task automatic report_mismatch(input string msg);
    // keep the log short when the block is badly broken
    if (fail_count < 100) $display("%0t ns mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                result_no, name, got, want));
  endtask

  always @(posedge clk) begin
    fate_t fate;
    if (rst) begin
      for (int i = 0; i < PIXEL_COUNT; i++) depth_mem[i] = '1;
      raster_cfg.depth_test_enable = 1'b0;
      raster_cfg.depth_func        = FUNC_LESS;
      raster_cfg.viewport_width    = 13'd256;
      predicted_fates.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_BITS-1:2])
          REG_DEPTH_TEST_ENABLE: raster_cfg.depth_test_enable = pwdata[0];
          REG_DEPTH_FUNC:        raster_cfg.depth_func        = pwdata[2:0];
          REG_VIEWPORT_WIDTH:    raster_cfg.viewport_width    = pwdata[12:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        fate = resolve_fragment();
        predicted_fates.push_back(fate);
        case (fate.outcome)
          OUT_WRITTEN:    written_count++;
          OUT_DEPTH_FAIL: depth_fail_count++;
          OUT_RANGE:      range_count++;
          default:        drop_count++;
        endcase
      end
      if (out_valid && !out_stall) begin
        result_no++;
        if (predicted_fates.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", result_no));
        end else begin
          fate = predicted_fates.pop_front();
          compare_field("outcome", 32'(outcome), 32'(fate.outcome));
          compare_field("color_write", 32'(color_write), 32'(fate.color_write));
          compare_field("pixel_index", 32'(pixel_index), 32'(fate.pixel_index));
          compare_field("red_out", 32'(red_out), 32'(fate.red));
          compare_field("green_out", 32'(green_out), 32'(fate.green));
          compare_field("blue_out", 32'(blue_out), 32'(fate.blue));
          compare_field("alpha_out", 32'(alpha_out), 32'(fate.alpha));
        end
      end
    end
    pending = predicted_fates.size();
  end

endmodule

// ----- verif/fragment_depth_test_color_write_test.sv -----
// Testbench top: drives fragments and raster settings into the depth test block.
module fragment_depth_test_color_write_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fdtcw_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 170;
  localparam int HOLD_CYCLES   = 400;
  localparam int TIMEOUT_NS    = 10_000_000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [PADDR_BITS-1:0] paddr     = '0;
  logic [PDATA_BITS-1:0] pwdata    = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [11:0]           pos_x     = '0;
  logic [11:0]           pos_y     = '0;
  logic [23:0]           frag_depth = '0;
  logic [7:0]            red_in    = '0;
  logic [7:0]            green_in  = '0;
  logic [7:0]            blue_in   = '0;
  logic [7:0]            alpha_in  = '0;
  logic                  is_ghost  = 1'b0;
  logic                  is_killed = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            outcome;
  logic                  color_write;
  logic [15:0]           pixel_index;
  logic [7:0]            red_out;
  logic [7:0]            green_out;
  logic [7:0]            blue_out;
  logic [7:0]            alpha_out;

  int          fail_count;
  int          pending;
  int          written_count;
  int          drop_count;
  int          depth_fail_count;
  int          range_count;
  int          sent_count     = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cur_width      = 256;
  bit          pressure_req   = 1'b0;
  bit          pressure_done  = 1'b0;
  int          hold_left      = 0;
  int unsigned hot_index [16];
  logic [23:0] depth_pool [8];

  fragment_depth_test_color_write u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .pos_x, .pos_y, .frag_depth,
    .red_in, .green_in, .blue_in, .alpha_in, .is_ghost, .is_killed,
    .out_valid, .out_stall, .outcome, .color_write, .pixel_index,
    .red_out, .green_out, .blue_out, .alpha_out
  );

  fragment_depth_test_color_write_checker u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_stall, .pos_x, .pos_y, .frag_depth,
    .red_in, .green_in, .blue_in, .alpha_in, .is_ghost, .is_killed,
    .out_valid, .out_stall, .outcome, .color_write, .pixel_index,
    .red_out, .green_out, .blue_out, .alpha_out,
    .fail_count, .pending, .written_count, .drop_count, .depth_fail_count, .range_count
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (pressure_req && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left     = HOLD_CYCLES - 1;
      out_stall     <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Stop offering, wait for every pending result, then let the pipe settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_raster_state(input logic en, input logic [2:0] func,
                                  input logic [12:0] width);
    logic [1:0]            reg_id [3];
    logic [PDATA_BITS-1:0] value  [3];
    drain_results();
    reg_id = '{REG_DEPTH_TEST_ENABLE, REG_DEPTH_FUNC, REG_VIEWPORT_WIDTH};
    value  = '{PDATA_BITS'(en), PDATA_BITS'(func), PDATA_BITS'(width)};
    for (int i = 0; i < 3; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_id[i], 2'b00};
      pwdata  <= value[i];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_width = 32'(width);
  endtask

  task automatic send_fragment(input logic [11:0] x, input logic [11:0] y,
                               input logic [23:0] z, input logic [31:0] rgba,
                               input logic ghost, input logic killed);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    pos_x      <= x;
    pos_y      <= y;
    frag_depth <= z;
    {red_in, green_in, blue_in, alpha_in} <= rgba;
    is_ghost   <= ghost;
    is_killed  <= killed;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // Place a pixel index on the current viewport; fails when no position reaches it.
  function automatic bit map_index(input int unsigned idx, output logic [11:0] x,
                                   output logic [11:0] y);
    int unsigned col;
    int unsigned row;
    if (cur_width == 0) begin
      row = $urandom_range(4095);
      col = idx;
    end else begin
      row = idx / cur_width;
      col = idx % cur_width;
      if (row > 4095) begin
        row = 4095;
        col = idx - 4095 * cur_width;
      end
    end
    x = col[11:0];
    y = row[11:0];
    return col <= 4095 && row <= 4095;
  endfunction

  task automatic random_fragment();
    int unsigned pick;
    int unsigned ymax;
    int unsigned xmax;
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] z;
    logic        ghost;
    logic        killed;
    bit          placed;
    pick   = $urandom_range(99);
    z      = $urandom_range(1) ? depth_pool[$urandom_range(7)] : 24'($urandom);
    x      = 12'($urandom);
    y      = 12'($urandom);
    ghost  = pick < 5;
    killed = (pick < 5) ? 1'($urandom_range(1)) : (pick < 10);
    placed = 1'b0;
    if (pick >= 20) begin
      // mostly revisit a few hot pixels so compares see written depths
      if (pick < 70) placed = map_index(hot_index[$urandom_range(15)], x, y);
      if (!placed) begin
        if (cur_width == 0) ymax = 4095;
        else ymax = (65535 / cur_width > 4095) ? 4095 : 65535 / cur_width;
        y    = 12'($urandom_range(ymax));
        xmax = (cur_width == 0) ? 4095 : 65535 - 32'(y) * cur_width;
        if (xmax > 4095) xmax = 4095;
        x    = 12'($urandom_range(xmax));
      end
    end
    send_fragment(x, y, z, $urandom, ghost, killed);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("fragment_depth_test_color_write_test: FAIL");
    $finish;
  end

  initial begin
    logic        en;
    logic [2:0]  func;
    logic [12:0] width;
    idle_mode_t  mode;
    for (int i = 0; i < 16; i++)
      hot_index[i] = (i < 8) ? $urandom_range(4095) : $urandom_range(65535);
    depth_pool = '{24'h000000, 24'h000001, 24'h7FFFFF, 24'h800000,
                   24'hFFFFFE, 24'hFFFFFF, 24'($urandom), 24'($urandom)};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: test off, width 256
    send_fragment(12'd0, 12'd0, 24'h000000, 32'h00000000, 1'b0, 1'b0);
    send_fragment(12'd4095, 12'd4095, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0);
    send_fragment(12'd4095, 12'd4095, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1);
    send_fragment(12'd1, 12'd2, 24'h123456, 32'h11223344, 1'b0, 1'b1);
    send_fragment(12'd3, 12'd4, 24'h654321, 32'h55667788, 1'b1, 1'b0);
    send_fragment(12'd255, 12'd255, 24'h000000, 32'hA5A5A5A5, 1'b0, 1'b0);
    send_fragment(12'd0, 12'd256, 24'h000000, 32'h5A5A5A5A, 1'b0, 1'b0);

    set_raster_state(1'b1, FUNC_LESS, 13'd256);
    send_fragment(12'd10, 12'd0, 24'hFFFFFF, 32'h01020304, 1'b0, 1'b0);
    send_fragment(12'd10, 12'd0, 24'h800000, 32'h05060708, 1'b0, 1'b0);
    send_fragment(12'd10, 12'd0, 24'h800000, 32'h090A0B0C, 1'b0, 1'b0);
    send_fragment(12'd255, 12'd255, 24'h000000, 32'h0D0E0F10, 1'b0, 1'b0);
    send_fragment(12'd10, 12'd0, 24'h000000, 32'hDEADBEEF, 1'b0, 1'b1);

    set_raster_state(1'b1, FUNC_EQUAL, 13'd256);
    send_fragment(12'd10, 12'd0, 24'h800000, 32'h80808080, 1'b0, 1'b0);
    send_fragment(12'd10, 12'd0, 24'h7FFFFF, 32'h7F7F7F7F, 1'b0, 1'b0);

    set_raster_state(1'b1, FUNC_NEVER, 13'd256);
    send_fragment(12'd255, 12'd255, 24'h000000, 32'hCAFEF00D, 1'b0, 1'b0);

    // zero width: the index is the column alone
    set_raster_state(1'b1, FUNC_ALWAYS, 13'd0);
    send_fragment(12'd4095, 12'd4095, 24'hFFFFFF, 32'h0F0F0F0F, 1'b0, 1'b0);
    send_fragment(12'd4095, 12'd4095, 24'h000000, 32'hF0F0F0F0, 1'b0, 1'b0);

    set_raster_state(1'b1, FUNC_GREATER, 13'd8191);
    send_fragment(12'd4095, 12'd7, 24'hFFFFFF, 32'h12345678, 1'b0, 1'b0);
    send_fragment(12'd0, 12'd8, 24'h000000, 32'h87654321, 1'b0, 1'b0);
    send_fragment(12'd8, 12'd8, 24'h000000, 32'h13579BDF, 1'b0, 1'b0);

    set_raster_state(1'b1, FUNC_GEQUAL, 13'd8191);
    send_fragment(12'd4095, 12'd7, 24'hFFFFFF, 32'h2468ACE0, 1'b0, 1'b0);
    set_raster_state(1'b1, FUNC_NOTEQUAL, 13'd8191);
    send_fragment(12'd4095, 12'd7, 24'hFFFFFF, 32'h3C3C3C3C, 1'b0, 1'b0);
    set_raster_state(1'b1, FUNC_LEQUAL, 13'd8191);
    send_fragment(12'd4095, 12'd7, 24'h000000, 32'hC3C3C3C3, 1'b0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin en = 1'b1; func = FUNC_LESS;     width = 13'd256;  mode = IDLE_NONE; end
        1:       begin en = 1'b1; func = FUNC_LEQUAL;   width = 13'd1;    mode = IDLE_SEND; end
        2:       begin en = 1'b1; func = FUNC_GREATER;  width = 13'd4096; mode = IDLE_RECV; end
        3:       begin en = 1'b1; func = FUNC_NOTEQUAL; width = 13'd8191; mode = IDLE_BOTH; end
        4:       begin en = 1'b1; func = FUNC_GEQUAL;   width = 13'd0;    mode = IDLE_NONE; end
        5:       begin en = 1'b1; func = FUNC_EQUAL;    width = 13'd100;  mode = IDLE_SEND; end
        6:       begin en = 1'b0; func = FUNC_LESS;     width = 13'd300;  mode = IDLE_RECV; end
        7:       begin en = 1'b1; func = FUNC_ALWAYS;   width = 13'd640;  mode = IDLE_BOTH; end
        8:       begin en = 1'b1; func = FUNC_NEVER;    width = 13'd4095; mode = IDLE_NONE; end
        default: begin en = 1'b1; func = FUNC_LESS;     width = 13'd256;  mode = IDLE_BOTH; end
      endcase
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      set_raster_state(en, func, width);
      case (mode)
        IDLE_SEND: send_gap_pct = 70;
        IDLE_RECV: recv_stall_pct = 70;
        IDLE_BOTH: begin send_gap_pct = 38; recv_stall_pct = 38; end
        default: ;
      endcase
      // hold the output off while fragments keep coming
      if (p == 0) pressure_req = 1'b1;
      repeat (PHASE_ITEMS) random_fragment();
    end

    drain_results();
    $display("covered %0d fragments: all eight compare functions, depth test on and off,",
             sent_count);
    $display("widths 0 to 8191, idle and stall mixes, one long output hold; %0d written, %0d %s",
             written_count, drop_count, $sformatf("ghost or killed, %0d depth fail, %0d out of range",
             depth_fail_count, range_count));
    if (fail_count == 0 && pending == 0) begin
      $display("fragment_depth_test_color_write_test: PASS");
    end else begin
      $display("fragment_depth_test_color_write_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- fragment_depth_test_color_write.f -----
+incdir+src
src/fdtcw_pkg.sv
src/fdtcw_ram.sv
src/fdtcw_cfg.sv
src/fragment_depth_test_color_write.sv
verif/fragment_depth_test_color_write_checker.sv
verif/fragment_depth_test_color_write_test.sv
